[design/decq_pkg.sv]
// Package for the deduplicating error code queue.
// Holds the queue constants, the opcode codes and the cell control struct.
// No dependencies.
`default_nettype none

package decq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CODE_W      = 32;
    localparam int CNT_W       = 8;
    localparam int REPORT_W    = 8;
    localparam int REPORT_LSB  = 16;

    typedef enum logic {
        OP_POST  = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    // Broadcast control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CODE_W-1:0] code;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[design/decq_cell.sv]
// One storage cell of the queue chain: a valid flag, a code and a match compare.
// Depends on decq_pkg.
`default_nettype none

module decq_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  decq_pkg::t_cell_ctrl         i_ctrl,
    input  wire                          i_prev_valid,
    input  wire                          i_next_valid,
    input  wire [decq_pkg::CODE_W-1:0]   i_next_code,
    output logic                         o_valid,
    output logic [decq_pkg::CODE_W-1:0]  o_code,
    output logic                         o_match
);
    import decq_pkg::*;

    logic              r_valid;
    logic [CODE_W-1:0] r_code;
    logic              n_valid;
    logic [CODE_W-1:0] n_code;

    // A pop shifts the chain toward the head; a push fills the first empty cell.
    always_comb begin
        n_valid = r_valid;
        n_code  = r_code;
        if (i_ctrl.pop) begin
            n_valid = i_next_valid;
            n_code  = i_next_code;
        end else if (i_ctrl.push && i_prev_valid && !r_valid) begin
            n_valid = 1'b1;
            n_code  = i_ctrl.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_code <= n_code;
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_match = r_valid && (r_code == i_ctrl.code);

endmodule

`default_nettype wire

[design/dedup_error_code_queue.sv]
// Deduplicating error code queue: a chain of cells with the oldest code in cell 0.
// Every item is taken as it arrives, so busy stays low and one item per cycle is accepted.
// A fetch gives its result in the cycle after it is accepted, on o_strobe for one cycle.
// A post gives no result. The receiver cannot stall the result.
// Synchronous active-low reset empties the queue, clears the repeat counter
// and sets the minimum repeat count to 1. No clearing pass is needed.
// Depends on decq_pkg and decq_cell.
`default_nettype none

module dedup_error_code_queue (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            i_opcode,
    input  wire [decq_pkg::CODE_W-1:0]     i_error_code,
    input  wire                            i_cfg_we,
    input  wire [decq_pkg::CNT_W-1:0]      i_cfg_wdata,
    output logic                           o_strobe,
    output logic [decq_pkg::REPORT_W-1:0]  o_reported_code
);
    import decq_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [CODE_W-1:0]      w_code [QUEUE_DEPTH];
    t_cell_ctrl             w_ctrl;

    logic                r_strobe;
    logic [REPORT_W-1:0] r_report;
    logic [CNT_W-1:0]    r_repeat;
    logic [CNT_W-1:0]    r_min;
    logic [CNT_W-1:0]    n_repeat;
    logic [CNT_W-1:0]    w_inc;
    logic                w_accept;
    logic                w_fetch;
    logic                w_post;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_fetch  = w_accept && (t_opcode'(i_opcode) == OP_FETCH);
    assign w_post   = w_accept && (t_opcode'(i_opcode) == OP_POST);

    assign w_inc = (r_repeat == CNT_MAX) ? CNT_MAX : r_repeat + 1'b1;

    always_comb begin
        w_ctrl.code = i_error_code;
        w_ctrl.push = w_post && (i_error_code != '0) && !w_valid[QUEUE_DEPTH-1]
                      && !(|w_match);
        w_ctrl.pop  = w_fetch && w_valid[0] && (w_inc >= r_min);
    end

    always_comb begin
        n_repeat = r_repeat;
        if (w_fetch && w_valid[0]) begin
            n_repeat = w_ctrl.pop ? '0 : w_inc;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic              w_prev_valid;
        logic              w_next_valid;
        logic [CODE_W-1:0] w_next_code;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH-1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_code  = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_code  = w_code[g+1];
        end

        decq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_code  (w_next_code),
            .o_valid      (w_valid[g]),
            .o_code       (w_code[g]),
            .o_match      (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_repeat <= '0;
            r_min    <= CNT_W'(1);
        end else begin
            r_strobe <= w_fetch;
            r_repeat <= n_repeat;
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
        end
        if (w_fetch) begin
            r_report <= w_valid[0] ? w_code[0][REPORT_LSB +: REPORT_W] : '0;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_reported_code = r_report;

    // A result appears only in the cycle after a fetch item was taken.
    a_strobe_follows_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && (i_opcode == OP_FETCH)))
        else $error("result strobe without a fetch item");

    // Held entries stay packed toward the head of the chain.
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & ~{w_valid[QUEUE_DEPTH-2:0], 1'b1}) == '0)
        else $error("gap in the cell chain");

    // A fetch of an empty queue reports zero.
    a_empty_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fetch && !w_valid[0]) |=> (o_reported_code == '0))
        else $error("empty fetch reported a nonzero code");

    // The repeat counter is clear whenever the queue is empty.
    a_counter_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> (r_repeat == '0))
        else $error("repeat counter set with an empty queue");

endmodule

`default_nettype wire
